@@ rtl/cdq_pkg.sv @@
`default_nettype none

package cdq_pkg;

    localparam int CAP_W         = 5;
    localparam int KIND_W        = 3;
    localparam int DATA_W        = 32;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
    localparam logic [DATA_W-1:0] FAIL_DATA = '1;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PEEK_FRONT = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PEEK_REAR  = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_OUT
    } cdq_state_t;

    // Per-operation control from the index logic to the top level.
    typedef struct packed {
        logic we;
        logic re;
        logic ok;
        logic is_empty;
        logic is_full;
    } cdq_op_t;

endpackage

`default_nettype wire

@@ rtl/circular_deque_top.sv @@
// Double-ended queue in a single-port ring RAM of DEPTH 32-bit entries, of which the
// capacity register selects how many are in use (zero acts as one, values above DEPTH
// as DEPTH); writing capacity empties the queue. Each input transfer is one operation
// and gives exactly one output transfer. A push, a failed operation or an unused kind
// offers its result in the cycle after the input transfer, a pop or peek only after
// a further ST_READ state, because the element comes from the registered RAM read.
// One operation is handled at a time: the input is ready again in the cycle after the
// result transfer completes.
`default_nettype none

module circular_deque_top #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata,   // capacity
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,     // value[31:0]
    input  wire logic [2:0]  s_tuser,     // kind[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,     // data[31:0], is_empty[32], is_full[33], zeros
    output logic      [0:0]  m_tuser      // ok[0]
);

    import cdq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    cdq_state_t        state_reg, state_next;
    cdq_op_t           op;
    logic [AW-1:0]     addr;
    logic [DATA_W-1:0] rdata;
    logic              fire;
    logic              ok_reg;
    logic              empty_reg;
    logic              full_reg;
    logic [DATA_W-1:0] data_reg;

    assign fire = s_tvalid && s_tready;

    cdq_ptr #(
        .DEPTH (DEPTH)
    ) u_ptr (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .op_fire   (fire),
        .kind      (s_tuser),
        .op        (op),
        .addr      (addr)
    );

    cdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (op.we),
        .re    (op.re),
        .addr  (addr),
        .wdata (s_tdata),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (fire)
                begin
                    state_next = op.re ? ST_READ : ST_OUT;
                end
            end
            ST_READ:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Result payload; a successful pop or peek replaces the data once the RAM answers.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ok_reg    <= op.ok;
            empty_reg <= op.is_empty;
            full_reg  <= op.is_full;
            data_reg  <= op.ok ? '0 : FAIL_DATA;
        end
        else if (state_reg == ST_READ)
        begin
            data_reg <= rdata;
        end
    end

    assign m_tdata = {6'b0, full_reg, empty_reg, data_reg};
    assign m_tuser = ok_reg;

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output are open in the same cycle");

    a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && op.re) |=> (!m_tvalid && !s_tready))
        else $error("pop or peek result did not wait for the RAM");

    a_no_ram_access_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |-> (!op.we && !op.re))
        else $error("RAM accessed without an accepted operation");

    a_fail_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !ok_reg) |-> (data_reg == FAIL_DATA))
        else $error("failed operation without all-ones data");

    a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(empty_reg && full_reg))
        else $error("queue reported empty and full at once");

endmodule

`default_nettype wire

@@ rtl/cdq_ram.sv @@
`default_nettype none

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/cdq_ptr.sv @@
`default_nettype none

module cdq_ptr #(
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [cdq_pkg::CAP_W-1:0]            cfg_wdata,
    input  wire logic                                 op_fire,
    input  wire logic [cdq_pkg::KIND_W-1:0]           kind,
    output cdq_pkg::cdq_op_t                          op,
    output logic      [$clog2(DEPTH)-1:0]             addr
);

    import cdq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int UW = (IW + 1 > CAP_W) ? IW + 1 : CAP_W;
    localparam logic [UW-1:0] DEPTH_U = UW'(DEPTH);

    logic [CAP_W-1:0] capacity_reg;
    logic [IW-1:0]    head_reg, head_next;
    logic [IW-1:0]    tail_reg, tail_next;
    logic             empty_reg, empty_next;
    logic [UW-1:0]    cap_ext;
    logic [UW-1:0]    cap_u;
    logic             full_now;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i,
                                               input logic [UW-1:0] cap);
        logic [UW-1:0] nxt;
        nxt = UW'(i) + UW'(1);
        wrap_inc = (nxt >= cap) ? '0 : nxt[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] i,
                                               input logic [UW-1:0] cap);
        logic [UW-1:0] last;
        last = cap - UW'(1);
        wrap_dec = (i == '0) ? last[IW-1:0] : i - IW'(1);
    endfunction

    // A capacity of zero behaves as one, and anything above the ring size as the ring size.
    assign cap_ext  = UW'(capacity_reg);
    assign cap_u    = (cap_ext == '0) ? UW'(1) : ((cap_ext > DEPTH_U) ? DEPTH_U : cap_ext);
    assign full_now = !empty_reg && (wrap_inc(tail_reg, cap_u) == head_reg);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        addr       = head_reg;
        op         = '0;
        case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_REAR:
            begin
                if (!full_now)
                begin
                    op.ok = 1'b1;
                    op.we = op_fire;
                    if (empty_reg)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b0;
                        addr       = '0;
                    end
                    else if (kind == KIND_PUSH_FRONT)
                    begin
                        head_next = wrap_dec(head_reg, cap_u);
                        addr      = head_next;
                    end
                    else
                    begin
                        tail_next = wrap_inc(tail_reg, cap_u);
                        addr      = tail_next;
                    end
                end
            end
            KIND_POP_FRONT, KIND_POP_REAR:
            begin
                if (!empty_reg)
                begin
                    op.ok = 1'b1;
                    op.re = op_fire;
                    addr  = (kind == KIND_POP_FRONT) ? head_reg : tail_reg;
                    if (head_reg == tail_reg)
                    begin
                        // The last element leaves, so both ends return to the start.
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b1;
                    end
                    else if (kind == KIND_POP_FRONT)
                    begin
                        head_next = wrap_inc(head_reg, cap_u);
                    end
                    else
                    begin
                        tail_next = wrap_dec(tail_reg, cap_u);
                    end
                end
            end
            KIND_PEEK_FRONT, KIND_PEEK_REAR:
            begin
                if (!empty_reg)
                begin
                    op.ok = 1'b1;
                    op.re = op_fire;
                    addr  = (kind == KIND_PEEK_FRONT) ? head_reg : tail_reg;
                end
            end
            default:
            begin
                op.ok = 1'b0;
            end
        endcase
        op.is_empty = empty_next;
        op.is_full  = !empty_next && (wrap_inc(tail_next, cap_u) == head_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            head_reg     <= '0;
            tail_reg     <= '0;
            empty_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
            head_reg     <= '0;
            tail_reg     <= '0;
            empty_reg    <= 1'b1;
        end
        else if (op_fire)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

endmodule

`default_nettype wire

@@ dv/tb_circular_deque_top.sv @@
`timescale 1ns / 100ps

module tb_circular_deque_top;

    import cdq_pkg::*;

    // Kinds that the block treats as no operation.
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    localparam int RING_DEPTH  = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SEGMENTS    = 12;
    localparam int SEG_ITEMS   = 140;

    localparam logic [DATA_W-1:0] VAL_MAX_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] VAL_MIN_NEG = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_ZERO    = 32'h0000_0000;
    localparam logic [DATA_W-1:0] VAL_ALL_ONE = 32'hFFFF_FFFF;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } op_mix_t;

    typedef struct {
        logic              ok;
        logic [DATA_W-1:0] data;
        logic              is_empty;
        logic              is_full;
    } deque_result_t;

    // Shadow deque: predicts each result and compares it with what the block returns.
    class deque_tracker;
        logic [DATA_W-1:0] ring [RING_DEPTH];
        logic [3:0]        head = '0;
        logic [3:0]        tail = '0;
        logic              empty = 1'b1;
        logic [CAP_W-1:0]  cap_reg = CAP_RESET;
        deque_result_t     expected_results [$];
        int                errors = 0;

        function int unsigned live_cap();
            if (cap_reg == 0)
                return 1;
            if (cap_reg > RING_DEPTH)
                return RING_DEPTH;
            return cap_reg;
        endfunction

        function logic [3:0] step_up(logic [3:0] idx, int unsigned cap);
            return (idx + 1 >= cap) ? 4'd0 : idx + 4'd1;
        endfunction

        function logic [3:0] step_down(logic [3:0] idx, int unsigned cap);
            return (idx == 0) ? 4'(cap - 1) : idx - 4'd1;
        endfunction

        function logic at_capacity(int unsigned cap);
            return !empty && step_up(tail, cap) == head;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] cap);
            cap_reg = cap;
            head    = '0;
            tail    = '0;
            empty   = 1'b1;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_op(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] value);
            deque_result_t r;
            int unsigned   cap;
            cap    = live_cap();
            r.ok   = 1'b0;
            r.data = FAIL_DATA;
            case (kind)
                KIND_PUSH_FRONT, KIND_PUSH_REAR:
                begin
                    if (!at_capacity(cap))
                    begin
                        if (empty)
                        begin
                            head    = '0;
                            tail    = '0;
                            empty   = 1'b0;
                            ring[0] = value;
                        end
                        else if (kind == KIND_PUSH_FRONT)
                        begin
                            head       = step_down(head, cap);
                            ring[head] = value;
                        end
                        else
                        begin
                            tail       = step_up(tail, cap);
                            ring[tail] = value;
                        end
                        r.ok   = 1'b1;
                        r.data = '0;
                    end
                end
                KIND_POP_FRONT, KIND_POP_REAR:
                begin
                    if (!empty)
                    begin
                        r.data = (kind == KIND_POP_FRONT) ? ring[head] : ring[tail];
                        r.ok   = 1'b1;
                        if (head == tail)
                        begin
                            head  = '0;
                            tail  = '0;
                            empty = 1'b1;
                        end
                        else if (kind == KIND_POP_FRONT)
                            head = step_up(head, cap);
                        else
                            tail = step_down(tail, cap);
                    end
                end
                KIND_PEEK_FRONT, KIND_PEEK_REAR:
                begin
                    if (!empty)
                    begin
                        r.data = (kind == KIND_PEEK_FRONT) ? ring[head] : ring[tail];
                        r.ok   = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            r.is_empty = empty;
            r.is_full  = at_capacity(cap);
            expected_results.push_back(r);
        endfunction

        function void check_result(logic ok, logic [DATA_W-1:0] data, logic is_empty,
                                   logic is_full);
            deque_result_t e;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected: ok=%0b data=%h empty=%0b full=%0b",
                         $time, ok, data, is_empty, is_full);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (ok !== e.ok)
            begin
                $display("%0t: ok mismatch: expected %0b, actual %0b", $time, e.ok, ok);
                errors++;
            end
            if (data !== e.data)
            begin
                $display("%0t: data mismatch: expected %h, actual %h", $time, e.data, data);
                errors++;
            end
            if (is_empty !== e.is_empty)
            begin
                $display("%0t: is_empty mismatch: expected %0b, actual %0b",
                         $time, e.is_empty, is_empty);
                errors++;
            end
            if (is_full !== e.is_full)
            begin
                $display("%0t: is_full mismatch: expected %0b, actual %0b",
                         $time, e.is_full, is_full);
                errors++;
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [CAP_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata   = '0;      // value[31:0]
    logic [KIND_W-1:0] s_tuser   = '0;      // kind[2:0]
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [39:0]       m_tdata;             // data[31:0], is_empty[32], is_full[33], zeros
    logic [0:0]        m_tuser;             // ok[0]

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;

    deque_tracker deque_sb = new();

    circular_deque_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: a transfer completes at an edge where valid and ready were both high.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                deque_sb.check_result(m_tuser[0], m_tdata[31:0], m_tdata[32], m_tdata[33]);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic issue_op(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        deque_sb.note_op(kind, value);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        s_tvalid <= 1'b0;
        while (deque_sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        deque_sb.set_capacity(cap);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        case (sel)
            0, 1:    return VAL_MAX_POS;
            2, 3:    return VAL_MIN_NEG;
            4, 5:    return VAL_ZERO;
            6, 7:    return VAL_ALL_ONE;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(op_mix_t mix);
        int r;
        int push_pct;
        int pop_pct;
        r = $urandom_range(99);
        if (r < 3)
            return $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
        push_pct = (mix == MIX_FILL) ? 65 : (mix == MIX_DRAIN) ? 20 : 40;
        pop_pct  = (mix == MIX_DRAIN) ? 65 : (mix == MIX_FILL) ? 20 : 40;
        r = $urandom_range(99);
        if (r < push_pct)
            return $urandom_range(1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
        if (r < push_pct + pop_pct)
            return $urandom_range(1) ? KIND_POP_REAR : KIND_POP_FRONT;
        return $urandom_range(1) ? KIND_PEEK_REAR : KIND_PEEK_FRONT;
    endfunction

    // Runs of filling, draining and even traffic so that the deque reaches full and
    // empty repeatedly; no-operation kinds are not counted.
    task automatic run_random_ops(int count);
        int                done;
        int                run_left;
        op_mix_t           mix;
        logic [KIND_W-1:0] kind;
        done     = 0;
        run_left = 0;
        mix      = MIX_EVEN;
        while (done < count)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(40, 4);
                mix      = op_mix_t'($urandom_range(2));
            end
            run_left--;
            kind = pick_kind(mix);
            issue_op(kind, pick_value());
            if (kind != KIND_SPARE_LO && kind != KIND_SPARE_HI)
                done++;
        end
    endtask

    logic [CAP_W-1:0] cap_plan [SEGMENTS] = '{5'd1, 5'd0, 5'd2, 5'd16, 5'd31, 5'd17,
                                               5'd3, 5'd5, 5'd8, 5'd15, 5'd4, 5'd16};

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty deque at the reset capacity: every failing operation and the spare kinds.
        issue_op(KIND_POP_FRONT, VAL_ZERO);
        issue_op(KIND_POP_REAR, VAL_ZERO);
        issue_op(KIND_PEEK_FRONT, VAL_ZERO);
        issue_op(KIND_PEEK_REAR, VAL_ZERO);
        issue_op(KIND_SPARE_LO, VAL_MAX_POS);
        issue_op(KIND_SPARE_HI, VAL_MIN_NEG);
        // First push into an empty deque, then both ends with extreme values.
        issue_op(KIND_PUSH_REAR, VAL_MAX_POS);
        issue_op(KIND_PUSH_FRONT, VAL_MIN_NEG);
        issue_op(KIND_PUSH_REAR, VAL_ALL_ONE);
        issue_op(KIND_PUSH_FRONT, VAL_ZERO);
        issue_op(KIND_PEEK_FRONT, VAL_ZERO);
        issue_op(KIND_PEEK_REAR, VAL_ZERO);
        issue_op(KIND_POP_FRONT, VAL_ZERO);
        issue_op(KIND_POP_REAR, VAL_ZERO);
        issue_op(KIND_POP_FRONT, VAL_ZERO);
        issue_op(KIND_POP_REAR, VAL_ZERO);

        // A single-entry deque is full after one push.
        write_capacity(5'd1);
        issue_op(KIND_PUSH_FRONT, 32'h0000_0005);
        issue_op(KIND_PUSH_REAR, VAL_MAX_POS);
        issue_op(KIND_PUSH_FRONT, VAL_MIN_NEG);
        issue_op(KIND_PEEK_FRONT, VAL_ZERO);
        issue_op(KIND_POP_REAR, VAL_ZERO);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            write_capacity(cap_plan[seg]);
            case (seg * 3 / SEGMENTS)
                0:
                begin
                    send_idle_pct  = 34;
                    recv_stall_pct = 69;
                end
                1:
                begin
                    send_idle_pct  = 69;
                    recv_stall_pct = 34;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            run_random_ops(SEG_ITEMS);
        end

        s_tvalid <= 1'b0;
        while (deque_sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (deque_sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ circular_deque_top.f @@
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/cdq_ptr.sv
rtl/circular_deque_top.sv
dv/tb_circular_deque_top.sv
